FILE: rtl/prnid_pkg.sv
// Shared types and constants for the planar RLE nibble image decoder.
`timescale 1ns / 1ps
`default_nettype none

package prnid_pkg;

    // Packet parser phase
    typedef enum logic [1:0] {
        PH_BASE = 2'd0,
        PH_CTRL = 2'd1,
        PH_NIB  = 2'd2
    } phase_t;

    // Result kind codes
    typedef enum logic [2:0] {
        K_RUN        = 3'd0,
        K_DONE       = 3'd1,
        K_TRUNC_PKT  = 3'd2,
        K_TRUNC_NIB  = 3'd3,
        K_OVR_RUN    = 3'd4,
        K_OVR_NIB    = 3'd5
    } kind_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_CHANNELS = 2'd0,
        REG_WIDTH    = 2'd1,
        REG_HEIGHT   = 2'd2,
        REG_PAYLOAD  = 2'd3
    } cfg_reg_t;

    localparam logic [7:0] CTRL_REPEAT = 8'h80;
    localparam logic [7:0] CTRL_COUNT  = 8'h7F;
    localparam logic [7:0] HI_NIBBLE   = 8'hF0;
    localparam logic [7:0] LO_NIBBLE   = 8'h0F;

    localparam int TDATA_W = 88;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  sample_value;
        logic [1:0]  plane;
        logic [15:0] row;
        logic [15:0] column;
        logic [7:0]  run_length;
        logic [31:0] bytes_consumed;
        logic        last;
    } result_t;

    function automatic result_t make_result(
        input kind_t       kind,
        input logic [7:0]  value,
        input logic [1:0]  plane,
        input logic [15:0] row,
        input logic [15:0] column,
        input logic [7:0]  run_length,
        input logic [31:0] bytes
    );
        result_t r;
        r.kind           = kind;
        r.sample_value   = value;
        r.plane          = plane;
        r.row            = row;
        r.column         = column;
        r.run_length     = run_length;
        r.bytes_consumed = bytes;
        r.last           = 1'b0;
        return r;
    endfunction

    function automatic logic [15:0] fit16(input logic [31:0] v);
        return v[15:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/planar_rle_nibble_image_decoder.sv
// Top level of the planar RLE nibble image decoder: packet parser and result queue.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Width  Contents
// s_*       in   8      tdata: data_byte[7:0]
// m_*       out  88+3   tdata: sample_value, plane, row, column, run_length,
//                       bytes_consumed (low bit up); tuser: kind; tlast: last
// cfg_*     in   32     write enable, register index, write data
//
// One payload byte is decoded in the cycle it is accepted: the parser state
// updates at once and up to three results land in a three-entry queue.
// The queue drains one result per cycle while m_tready is high; a new byte
// is taken when the queue holds nothing after this cycle's drain. A status
// result (done or error) puts the parser back to its reset state. Reset
// clears parser state, queue count and loads the configuration defaults;
// m_tready low simply holds the queue.

module planar_rle_nibble_image_decoder #(
    parameter int MAX_DIM = 65535
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // data_byte[7:0]
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,
    // sample_value[7:0], plane[9:8], row[25:10], column[41:26],
    // run_length[49:42], bytes_consumed[81:50], zero fill above
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [prnid_pkg::TDATA_W-1:0]      m_tdata,
    // kind[2:0]
    output logic [2:0]                         m_tuser,
    output logic                               m_tlast,
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [31:0]                   cfg_wdata
);
    import prnid_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam logic [15:0] MAX_DIM16 = 16'(MAX_DIM);

    // configuration
    logic [2:0]  channels_reg;
    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic [31:0] payload_reg;

    // parser state
    phase_t           phase_reg, phase_next;
    logic [7:0]       base_reg, base_next;
    logic [6:0]       nl_reg, nl_next;
    logic [DIM_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] row_reg, row_next;
    logic [1:0]       plane_reg, plane_next;
    logic [31:0]      bc_reg, bc_next;

    // result queue
    result_t    q_reg [3];
    logic [1:0] qcnt_reg;

    // step logic
    result_t          res [3];
    logic [1:0]       res_n;
    logic             restart;
    logic [DIM_W-1:0] w_eff, h_eff;
    logic [2:0]       planes_eff;
    logic [31:0]      bc_inc;
    logic [DIM_W:0]   x1;
    logic [DIM_W+7:0] run_end;
    logic [6:0]       need;
    logic [7:0]       hi;
    logic [6:0]       nl_dec;
    logic             fits_now;
    logic             ep_req;
    logic [DIM_W-1:0] ep_col;
    logic             ep_wrap, ep_row_wrap, ep_done, ep_trunc;
    logic [DIM_W:0]   ep_row_inc;
    logic [2:0]       ep_plane_inc;
    logic [DIM_W-1:0] ep_col_out, ep_row_out;
    logic [1:0]       ep_plane_out;
    logic             accept, pop;

    assign pop      = m_tvalid && m_tready;
    assign s_tready = (qcnt_reg == 2'd0) || ((qcnt_reg == 2'd1) && m_tready);
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = (qcnt_reg != 2'd0);
    assign m_tuser  = q_reg[0].kind;
    assign m_tlast  = q_reg[0].last;
    assign m_tdata  = {6'd0, q_reg[0].bytes_consumed, q_reg[0].run_length,
                       q_reg[0].column, q_reg[0].row, q_reg[0].plane,
                       q_reg[0].sample_value};

    // effective dimensions
    always_comb
    begin
        w_eff = (width_reg > MAX_DIM16) ? DIM_W'(MAX_DIM) : DIM_W'(width_reg);
        h_eff = (height_reg > MAX_DIM16) ? DIM_W'(MAX_DIM) : DIM_W'(height_reg);
        if (channels_reg < 3'd3)
            planes_eff = 3'd3;
        else if (channels_reg > 3'd4)
            planes_eff = 3'd4;
        else
            planes_eff = channels_reg;
    end

    assign bc_inc   = bc_reg + 32'd1;
    assign x1       = {1'b0, col_reg} + (DIM_W+1)'(1);
    assign run_end  = {7'b0, x1} + (DIM_W+8)'(s_tdata[6:0]);
    assign need     = 7'(({1'b0, s_tdata[6:0]} + 8'd1) >> 1);
    assign hi       = base_reg & HI_NIBBLE;
    assign nl_dec   = nl_reg - 7'd1;
    assign fits_now = ({1'b0, bc_reg} + 33'd2) <= {1'b0, payload_reg};

    // one byte's worth of decoding
    always_comb
    begin
        phase_next = phase_reg;
        base_next  = base_reg;
        nl_next    = nl_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        plane_next = plane_reg;
        bc_next    = bc_reg;
        restart    = 1'b0;
        ep_req     = 1'b0;
        ep_col     = '0;
        res_n      = 2'd0;
        for (int i = 0; i < 3; i++)
            res[i] = '0;

        case (phase_reg)
            PH_CTRL:
            begin
                bc_next = bc_inc;
                if ((s_tdata & CTRL_REPEAT) != 8'd0) begin
                    if (run_end > {8'b0, w_eff}) begin
                        res[0]  = make_result(K_OVR_RUN, 8'd0, plane_reg,
                                              fit16(32'(row_reg)), fit16(32'(x1)),
                                              8'd0, bc_inc);
                        res_n   = 2'd1;
                        restart = 1'b1;
                    end
                    else begin
                        res[0] = make_result(K_RUN, base_reg, plane_reg,
                                             fit16(32'(row_reg)), fit16(32'(col_reg)),
                                             8'(s_tdata & CTRL_COUNT) + 8'd1, 32'd0);
                        res_n  = 2'd1;
                        ep_req = 1'b1;
                        ep_col = run_end[DIM_W-1:0];
                    end
                end
                else if (({1'b0, bc_inc} + 33'(need)) > {1'b0, payload_reg}) begin
                    res[0]  = make_result(K_TRUNC_NIB, 8'd0, plane_reg,
                                          fit16(32'(row_reg)), fit16(32'(x1)),
                                          8'd0, bc_inc);
                    res_n   = 2'd1;
                    restart = 1'b1;
                end
                else if (run_end > {8'b0, w_eff}) begin
                    res[0]  = make_result(K_OVR_NIB, 8'd0, plane_reg,
                                          fit16(32'(row_reg)), fit16(32'(x1)),
                                          8'd0, bc_inc);
                    res_n   = 2'd1;
                    restart = 1'b1;
                end
                else begin
                    res[0]   = make_result(K_RUN, base_reg, plane_reg,
                                           fit16(32'(row_reg)), fit16(32'(col_reg)),
                                           8'd1, 32'd0);
                    res_n    = 2'd1;
                    col_next = x1[DIM_W-1:0];
                    nl_next  = s_tdata[6:0];
                    if (s_tdata[6:0] == 7'd0) begin
                        ep_req = 1'b1;
                        ep_col = x1[DIM_W-1:0];
                    end
                    else begin
                        phase_next = PH_NIB;
                    end
                end
            end

            PH_NIB:
            begin
                bc_next = bc_inc;
                res[0]  = make_result(K_RUN, hi | (s_tdata >> 4), plane_reg,
                                      fit16(32'(row_reg)), fit16(32'(col_reg)),
                                      8'd1, 32'd0);
                res_n   = 2'd1;
                // second nibble of the byte, if the packet still wants it
                if (nl_dec != 7'd0) begin
                    res[1]   = make_result(K_RUN, hi | (s_tdata & LO_NIBBLE), plane_reg,
                                           fit16(32'(row_reg)),
                                           fit16(32'(col_reg + DIM_W'(1))),
                                           8'd1, 32'd0);
                    res_n    = 2'd2;
                    col_next = col_reg + DIM_W'(2);
                    nl_next  = nl_reg - 7'd2;
                end
                else begin
                    col_next = col_reg + DIM_W'(1);
                    nl_next  = nl_dec;
                end
                if (nl_next == 7'd0) begin
                    ep_req = 1'b1;
                    ep_col = col_next;
                end
            end

            default:
            begin
                // expecting a base byte
                if (!fits_now) begin
                    res[0]  = make_result(K_TRUNC_PKT, 8'd0, plane_reg,
                                          fit16(32'(row_reg)), fit16(32'(col_reg)),
                                          8'd0, bc_reg);
                    res_n   = 2'd1;
                    restart = 1'b1;
                end
                else begin
                    base_next  = s_tdata;
                    bc_next    = bc_inc;
                    phase_next = PH_CTRL;
                end
            end
        endcase

        // end of packet: advance row and plane, then look ahead for truncation
        ep_wrap      = (ep_col >= w_eff);
        ep_row_inc   = {1'b0, row_reg} + (DIM_W+1)'(1);
        ep_row_wrap  = ep_wrap && (ep_row_inc >= {1'b0, h_eff});
        ep_plane_inc = {1'b0, plane_reg} + 3'd1;
        ep_done      = ep_row_wrap && (ep_plane_inc >= planes_eff);
        ep_col_out   = ep_wrap ? '0 : ep_col;
        ep_row_out   = ep_wrap ? (ep_row_wrap ? '0 : ep_row_inc[DIM_W-1:0]) : row_reg;
        ep_plane_out = ep_row_wrap ? ep_plane_inc[1:0] : plane_reg;
        ep_trunc     = !ep_done &&
                       (({1'b0, bc_next} + 33'd2) > {1'b0, payload_reg});

        if (ep_req) begin
            phase_next = PH_BASE;
            nl_next    = 7'd0;
            col_next   = ep_col_out;
            row_next   = ep_row_out;
            plane_next = ep_plane_out;
            if (ep_done) begin
                res[res_n] = make_result(K_DONE, 8'd0, 2'd0, 16'd0, 16'd0, 8'd0, bc_next);
                res_n      = res_n + 2'd1;
                restart    = 1'b1;
            end
            else if (ep_trunc) begin
                res[res_n] = make_result(K_TRUNC_PKT, 8'd0, ep_plane_out,
                                         fit16(32'(ep_row_out)), fit16(32'(ep_col_out)),
                                         8'd0, bc_next);
                res_n      = res_n + 2'd1;
                restart    = 1'b1;
            end
        end

        if (restart) begin
            phase_next = PH_BASE;
            base_next  = 8'd0;
            nl_next    = 7'd0;
            col_next   = '0;
            row_next   = '0;
            plane_next = 2'd0;
            bc_next    = 32'd0;
        end

        for (int i = 0; i < 3; i++)
            res[i].last = (res_n != 2'd0) && (2'(i) == res_n - 2'd1);
    end

    // configuration and parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            channels_reg <= 3'd4;
            width_reg    <= 16'd1;
            height_reg   <= 16'd1;
            payload_reg  <= 32'd0;
            phase_reg    <= PH_BASE;
            base_reg     <= 8'd0;
            nl_reg       <= 7'd0;
            col_reg      <= '0;
            row_reg      <= '0;
            plane_reg    <= 2'd0;
            bc_reg       <= 32'd0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_CHANNELS: channels_reg <= cfg_wdata[2:0];
                    REG_WIDTH:    width_reg    <= cfg_wdata[15:0];
                    REG_HEIGHT:   height_reg   <= cfg_wdata[15:0];
                    REG_PAYLOAD:  payload_reg  <= cfg_wdata;
                    default:      payload_reg  <= payload_reg;
                endcase
            end
            if (accept) begin
                phase_reg <= phase_next;
                base_reg  <= base_next;
                nl_reg    <= nl_next;
                col_reg   <= col_next;
                row_reg   <= row_next;
                plane_reg <= plane_next;
                bc_reg    <= bc_next;
            end
        end
    end

    // result queue: slot 0 is the head
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            qcnt_reg <= 2'd0;
        end
        else if (accept) begin
            qcnt_reg <= res_n;
        end
        else if (pop) begin
            qcnt_reg <= qcnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            q_reg[0] <= res[0];
            q_reg[1] <= res[1];
            q_reg[2] <= res[2];
        end
        else if (pop) begin
            q_reg[0] <= q_reg[1];
            q_reg[1] <= q_reg[2];
        end
    end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the planar RLE nibble image decoder: predicted vs. streamed results.
module testbench;
    import prnid_pkg::*;

    localparam int CYCLE_LIMIT     = 300000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 56;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_CYCLES     = 250;

    // Small image (3 planes, 4x1): one repeat packet for plane 0, nibble packet
    // with an odd count, repeat-one and nibble-zero packets, a finished image
    // in the same item as its last run, then a run overrun and a nibble overrun.
    localparam logic [7:0] IMAGE_BYTES [18] = '{
        8'hFF, 8'h83,
        8'h5A, 8'h03, 8'h12, 8'h30,
        8'h00, 8'h80, 8'h10, 8'h00, 8'h20, 8'h81,
        8'h11, 8'h85,
        8'h22, 8'h05
        , 8'h00, 8'h00
    };
    // Payload of three bytes: a base byte truncated by the bytes already counted,
    // then a packet whose nibble item yields one run and a truncated-packet status.
    localparam logic [7:0] SHORT_BYTES [5] = '{8'h7F, 8'h7F, 8'h01, 8'h02, 8'hAB};

    // Predicts the decoder's results item by item and checks the DUT stream.
    class decode_checker;
        int unsigned n_planes_reg, width_reg, height_reg, payload_reg;
        phase_t      phase;
        logic [7:0]  base_byte;
        int unsigned nib_left, col_pos, row_pos, plane_pos, byte_cnt;
        result_t     pending_results[$];
        result_t     step_results[$];
        int          fail_count;

        function new();
            n_planes_reg = 4;
            width_reg    = 1;
            height_reg   = 1;
            payload_reg  = 0;
            fail_count   = 0;
            clear_state();
        endfunction

        function void clear_state();
            phase     = PH_BASE;
            base_byte = 8'd0;
            nib_left  = 0;
            col_pos   = 0;
            row_pos   = 0;
            plane_pos = 0;
            byte_cnt  = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [31:0] v);
            case (idx)
                REG_CHANNELS: n_planes_reg = v[2:0];
                REG_WIDTH:    width_reg    = v[15:0];
                REG_HEIGHT:   height_reg   = v[15:0];
                REG_PAYLOAD:  payload_reg  = v;
                default:      ;
            endcase
        endfunction

        function int unsigned planes();
            if (n_planes_reg < 3) return 3;
            if (n_planes_reg > 4) return 4;
            return n_planes_reg;
        endfunction

        function void emit(kind_t k, logic [7:0] v, int unsigned c, int unsigned len,
                           int unsigned nb);
            result_t r;
            r.kind           = k;
            r.sample_value   = v;
            r.plane          = (k == K_DONE) ? 2'd0 : plane_pos[1:0];
            r.row            = (k == K_DONE) ? 16'd0 : row_pos[15:0];
            r.column         = c[15:0];
            r.run_length     = len[7:0];
            r.bytes_consumed = nb;
            r.last           = 1'b0;
            step_results.push_back(r);
        endfunction

        function bit packet_fits();
            return {32'd0, byte_cnt} + 64'd2 <= {32'd0, payload_reg};
        endfunction

        // Packet finished: advance row/plane, report done or a short payload.
        function void close_packet();
            phase    = PH_BASE;
            nib_left = 0;
            if (col_pos >= width_reg) begin
                col_pos = 0;
                row_pos = (row_pos + 1) & 32'hFFFF;
                if (row_pos >= height_reg) begin
                    row_pos   = 0;
                    plane_pos = (plane_pos + 1) & 7;
                    if (plane_pos >= planes()) begin
                        emit(K_DONE, 8'd0, 0, 0, byte_cnt);
                        clear_state();
                        return;
                    end
                end
            end
            if (!packet_fits()) begin
                emit(K_TRUNC_PKT, 8'd0, col_pos, 0, byte_cnt);
                clear_state();
            end
        endfunction

        function void take_byte(logic [7:0] b);
            int unsigned x1;
            int unsigned cnt;
            logic [7:0]  hi;
            step_results.delete();
            if (phase == PH_CTRL) begin
                x1 = col_pos + 1;
                byte_cnt++;
                if (b[7]) begin
                    cnt = b[6:0];
                    if (x1 + cnt > width_reg) begin
                        emit(K_OVR_RUN, 8'd0, x1, 0, byte_cnt);
                        clear_state();
                    end else begin
                        emit(K_RUN, base_byte, col_pos, 1 + cnt, 0);
                        col_pos = x1 + cnt;
                        close_packet();
                    end
                end else begin
                    cnt = b;
                    if ({32'd0, byte_cnt} + (cnt + 1) / 2 > {32'd0, payload_reg}) begin
                        emit(K_TRUNC_NIB, 8'd0, x1, 0, byte_cnt);
                        clear_state();
                    end else if (x1 + cnt > width_reg) begin
                        emit(K_OVR_NIB, 8'd0, x1, 0, byte_cnt);
                        clear_state();
                    end else begin
                        emit(K_RUN, base_byte, col_pos, 1, 0);
                        col_pos  = x1;
                        nib_left = cnt;
                        if (cnt == 0) close_packet();
                        else phase = PH_NIB;
                    end
                end
            end else if (phase == PH_NIB) begin
                hi = base_byte & HI_NIBBLE;
                byte_cnt++;
                emit(K_RUN, hi | (b >> 4), col_pos, 1, 0);
                col_pos++;
                nib_left--;
                if (nib_left > 0) begin
                    emit(K_RUN, hi | (b & LO_NIBBLE), col_pos, 1, 0);
                    col_pos++;
                    nib_left--;
                end
                if (nib_left == 0) close_packet();
            end else begin
                if (!packet_fits()) begin
                    // base byte dropped
                    emit(K_TRUNC_PKT, 8'd0, col_pos, 0, byte_cnt);
                    clear_state();
                end else begin
                    base_byte = b;
                    byte_cnt++;
                    phase = PH_CTRL;
                end
            end
            if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
            foreach (step_results[i]) pending_results.push_back(step_results[i]);
        endfunction

        function string describe(result_t r);
            return $sformatf("kind=%0d value=%02h plane=%0d row=%0d col=%0d len=%0d bytes=%0d last=%0d",
                             r.kind, r.sample_value, r.plane, r.row, r.column,
                             r.run_length, r.bytes_consumed, r.last);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) $display("unexpected result: %s", describe(got));
                return;
            end
            want = pending_results.pop_front();
            if (got.kind !== want.kind || got.sample_value !== want.sample_value ||
                got.plane !== want.plane || got.row !== want.row ||
                got.column !== want.column || got.run_length !== want.run_length ||
                got.bytes_consumed !== want.bytes_consumed || got.last !== want.last) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("result mismatch at %0t", $realtime);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic [7:0]         s_tdata   = 8'd0;
    logic               m_tready  = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [1:0]         cfg_index = 2'd0;
    logic [31:0]        cfg_wdata = 32'd0;
    wire                s_tready;
    wire                m_tvalid;
    wire [TDATA_W-1:0]  m_tdata;
    wire [2:0]          m_tuser;
    wire                m_tlast;

    int send_idle_pct  = 0;     // chance per cycle that the byte source idles
    int recv_stall_pct = 0;     // chance per cycle that the result sink stalls
    int hold_request   = 0;     // long sink hold-off, picked up by the sink process
    int hold_cnt       = 0;
    int cycle_count;

    decode_checker image_pred = new();

    planar_rle_nibble_image_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),      // data_byte[7:0]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),      // sample_value, plane, row, column, run_length, bytes_consumed
        .m_tuser   (m_tuser),      // kind[2:0]
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result sink: random stalls, plus a long hold-off on request so the
    // result queue fills and the decoder has to back-pressure its input.
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_cnt     = hold_request;
            hold_request = 0;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Sample both handshakes on the rising edge. The accepted byte is predicted
    // before the result check so a same-cycle result would find its expectation.
    always @(posedge clk)
    begin : monitor
        result_t got;
        if (rst_n && s_tvalid && s_tready) image_pred.take_byte(s_tdata);
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind           = kind_t'(m_tuser);
            got.sample_value   = m_tdata[7:0];
            got.plane          = m_tdata[9:8];
            got.row            = m_tdata[25:10];
            got.column         = m_tdata[41:26];
            got.run_length     = m_tdata[49:42];
            got.bytes_consumed = m_tdata[81:50];
            got.last           = m_tlast;
            image_pred.check_result(got);
        end
    end

    // Next random byte. Mostly well-formed: on a control byte the count is
    // chosen to fit the rest of the row, so images actually complete; about
    // one control byte in ten is plain noise.
    function automatic logic [7:0] pick_byte();
        int unsigned room;
        if ($urandom_range(99) < 10 || image_pred.phase != PH_CTRL ||
            image_pred.col_pos + 1 > image_pred.width_reg)
            return 8'($urandom_range(255));
        room = image_pred.width_reg - image_pred.col_pos - 1;
        if (room > 127) room = 127;
        if ($urandom_range(1))
            return CTRL_REPEAT | 8'($urandom_range(room));
        return 8'($urandom_range(room));
    endfunction

    // Offer one item; the source may idle first. Returns after acceptance.
    task automatic send_item(input bit fixed, input logic [7:0] fixed_byte);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= fixed ? fixed_byte : pick_byte();
        do @(posedge clk); while (!s_tready);
    endtask

    // Drop valid and wait until every predicted result has come back, then
    // wait SETTLE_CYCLES more for a base byte that produced nothing.
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (image_pred.pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        image_pred.write_reg(idx, v);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic write_all(input logic [31:0] ch, input logic [31:0] w,
                             input logic [31:0] h, input logic [31:0] pl);
        write_reg(REG_CHANNELS, ch);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_PAYLOAD, pl);
    endtask

    initial
    begin : watchdog
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        logic [31:0] ch, w, h, pl;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings leave no payload: the first base byte is truncated.
        send_item(1'b1, 8'h00);
        settle();
        write_all(32'd3, 32'd4, 32'd1, 32'd100);
        foreach (IMAGE_BYTES[i]) send_item(1'b1, IMAGE_BYTES[i]);
        settle();
        write_reg(REG_PAYLOAD, 32'd3);
        foreach (SHORT_BYTES[i]) send_item(1'b1, SHORT_BYTES[i]);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            ch = $urandom_range(3, 4);
            w  = $urandom_range(1, 10);
            h  = $urandom_range(1, 3);
            pl = $urandom_range(8, 400);
            case (p)
                1:
                begin
                    // largest image and payload, channel count clamped down
                    ch = 32'd7;
                    w  = 32'd65535;
                    h  = 32'd65535;
                    pl = 32'hFFFF_FFFF;
                end
                2:
                begin
                    // zero width: every packet overruns or truncates; channel count clamped up
                    ch = 32'd0;
                    w  = 32'd0;
                    h  = 32'd4;
                end
                3:
                begin
                    // zero height: one row per plane
                    w = 32'd3;
                    h = 32'd0;
                end
                6: ch = $urandom_range(7);
                default: ;
            endcase
            write_all(ch, w, h, pl);

            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 78;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 78;
                end
                default:
                begin
                    send_idle_pct  = 16;
                    recv_stall_pct = 16;
                end
            endcase
            // Back-pressure: sink holds off while the source keeps offering.
            if (p == 4) hold_request = HOLD_CYCLES;

            repeat (ITEMS_PER_PHASE) send_item(1'b0, 8'h00);
        end

        settle();
        if (image_pred.fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
